// File: src/max_min_task_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Max-min scheduler assertion macros
// Concurrent checks, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef MAX_MIN_TASK_SCHEDULER_DEFINES_SVH
`define MAX_MIN_TASK_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MMTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define MMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/mmts_pkg.sv
// ----------------------------------------------------------------------------
// Max-min scheduler package
// Field widths, register codes and reset values shared by the block.
// ----------------------------------------------------------------------------
package mmts_pkg;

  localparam int EXEC_W     = 16;
  localparam int TASK_IDX_W = 4;
  localparam int VM_IDX_W   = 3;
  localparam int CHOSEN_W   = 24;
  localparam int TOTAL_W    = 32;

  localparam int VM_CNT_W   = 4;
  localparam int TASK_CNT_W = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VM_COUNT   = 2'd0,
    CFG_TASK_COUNT = 2'd1
  } cfg_idx_e;

  localparam logic [VM_CNT_W-1:0]   VM_COUNT_RST   = 4'd8;
  localparam logic [TASK_CNT_W-1:0] TASK_COUNT_RST = 5'd16;

endpackage

// File: src/mmts_in_if.sv
// ----------------------------------------------------------------------------
// Matrix input channel
// Valid/ready channel carrying one completion time per beat.
// ----------------------------------------------------------------------------
interface mmts_in_if;
  logic                        valid;
  logic                        ready;
  logic [mmts_pkg::EXEC_W-1:0] exec_time;

  modport source (output valid, output exec_time, input ready);
  modport sink (input valid, input exec_time, output ready);
endinterface

// File: src/mmts_out_if.sv
// ----------------------------------------------------------------------------
// Schedule result channel
// Valid/ready channel carrying one task assignment per beat.
// ----------------------------------------------------------------------------
interface mmts_out_if;
  logic                            valid;
  logic                            ready;
  logic [mmts_pkg::TASK_IDX_W-1:0] task_index;
  logic [mmts_pkg::VM_IDX_W-1:0]   vm_index;
  logic [mmts_pkg::CHOSEN_W-1:0]   chosen_time;
  logic [mmts_pkg::TOTAL_W-1:0]    running_total;
  logic                            is_last;

  modport source (output valid, output task_index, output vm_index, output chosen_time,
                  output running_total, output is_last, input ready);
  modport sink (input valid, input task_index, input vm_index, input chosen_time,
                input running_total, input is_last, output ready);
endinterface

// File: src/max_min_task_scheduler.sv
// ----------------------------------------------------------------------------
// Max-min task scheduler
// Loads a tasks-by-VMs completion-time matrix and emits a max-min schedule.
// ----------------------------------------------------------------------------
// Usage: write vm_count (index 0) and task_count (index 1) while idle; a write
// restarts any partial load. Send task_count * vm_count completion times on
// task_in, row-major, one beat per cycle while the two-entry queue has room.
// After the last value the scheduler runs task_count rounds and sends one
// beat per round on sched_out; is_last marks the final one.
// Each round walks the matrix RAM through its single read port: it reads all
// tasks * vms entries to find the max-min entry, issues the result, then
// does a read-modify-write over the chosen VM's column, one entry per task.
// While rounds run, task_in is held off once the queue fills. A stalled
// sched_out holds the next round at its issue step; the result register lets
// loading of the next matrix begin while the final beat waits.
// Reset: 8 VMs, 16 tasks, no load in progress. Matrix storage is not
// cleared; every schedule reads only what its own load wrote.
// ----------------------------------------------------------------------------
`include "max_min_task_scheduler_defines.svh"

module max_min_task_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int MAX_VMS   = 8,
  parameter int TIME_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mmts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mmts_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  mmts_in_if.sink                            task_in,
  mmts_out_if.source                         sched_out
);

  import mmts_pkg::*;

  localparam int AW     = (MAX_TASKS * MAX_VMS > 1) ? $clog2(MAX_TASKS * MAX_VMS) : 1;
  localparam int TCW    = $clog2(MAX_TASKS + 1);
  localparam int VCW    = $clog2(MAX_VMS + 1);
  localparam int ITEM_W = 1 + AW + EXEC_W;

  logic [VM_CNT_W-1:0]   vm_count_q;
  logic [TASK_CNT_W-1:0] task_count_q;
  logic [VCW-1:0]        vms;
  logic [TCW-1:0]        tasks;
  logic                  cfg_clear;
  logic                  fq_valid;
  logic                  fq_ready;
  logic [ITEM_W-1:0]     fq_item;
  logic                  bq_valid;
  logic                  bq_ready;
  logic [ITEM_W-1:0]     bq_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_count_q   <= VM_COUNT_RST;
      task_count_q <= TASK_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VM_COUNT:   vm_count_q   <= cfg_data_i[VM_CNT_W-1:0];
        CFG_TASK_COUNT: task_count_q <= cfg_data_i[TASK_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_clear = cfg_we_i && ((cfg_idx_i == CFG_VM_COUNT) ||
                                  (cfg_idx_i == CFG_TASK_COUNT));

  always_comb begin
    if (vm_count_q == '0) begin
      vms = VCW'(1);
    end else if (int'(vm_count_q) > MAX_VMS) begin
      vms = VCW'(MAX_VMS);
    end else begin
      vms = VCW'(vm_count_q);
    end
    if (task_count_q == '0) begin
      tasks = TCW'(1);
    end else if (int'(task_count_q) > MAX_TASKS) begin
      tasks = TCW'(MAX_TASKS);
    end else begin
      tasks = TCW'(task_count_q);
    end
  end

  mmts_front #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_VMS   (MAX_VMS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_clear),
    .vms_i     (vms),
    .tasks_i   (tasks),
    .task_in   (task_in),
    .q_valid_o (fq_valid),
    .q_item_o  (fq_item),
    .q_ready_i (fq_ready)
  );

  mmts_fifo #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fq_valid),
    .in_ready_o  (fq_ready),
    .in_data_i   (fq_item),
    .out_valid_o (bq_valid),
    .out_ready_i (bq_ready),
    .out_data_o  (bq_item)
  );

  mmts_back #(
    .MAX_TASKS (MAX_TASKS),
    .MAX_VMS   (MAX_VMS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vms_i     (vms),
    .tasks_i   (tasks),
    .q_valid_i (bq_valid),
    .q_item_i  (bq_item),
    .q_ready_o (bq_ready),
    .sched_out (sched_out)
  );

  `MMTS_ASSERT_SAME(a_result_not_during_load, clk_i, rst_ni, $rose(sched_out.valid), !(bq_valid && bq_ready), "result raised while matrix beats still drain")
  `MMTS_ASSERT_NEXT(a_hold_while_stalled, clk_i, rst_ni, sched_out.valid && !sched_out.ready, (sched_out.valid && $stable(sched_out.task_index) && $stable(sched_out.vm_index) && $stable(sched_out.chosen_time) && $stable(sched_out.running_total) && $stable(sched_out.is_last)), "result beat changed while stalled")

endmodule

// File: src/mmts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mmts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/mmts_fifo.sv
// ----------------------------------------------------------------------------
// Two-entry queue
// Decouples the load front end from the scheduling back end.
// ----------------------------------------------------------------------------
module mmts_fifo #(
  parameter int WIDTH = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push;
  logic             pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// File: src/mmts_front.sv
// ----------------------------------------------------------------------------
// Load front end
// Takes matrix beats, tags each with its matrix address and end of load.
// ----------------------------------------------------------------------------
module mmts_front #(
  parameter int MAX_TASKS = 16,
  parameter int MAX_VMS   = 8,
  localparam int TW       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int VW       = (MAX_VMS > 1) ? $clog2(MAX_VMS) : 1,
  localparam int AW       = (MAX_TASKS * MAX_VMS > 1) ? $clog2(MAX_TASKS * MAX_VMS) : 1,
  localparam int TCW      = $clog2(MAX_TASKS + 1),
  localparam int VCW      = $clog2(MAX_VMS + 1),
  localparam int ITEM_W   = 1 + AW + mmts_pkg::EXEC_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic [VCW-1:0]    vms_i,
  input  logic [TCW-1:0]    tasks_i,
  mmts_in_if.sink           task_in,
  output logic              q_valid_o,
  output logic [ITEM_W-1:0] q_item_o,
  input  logic              q_ready_i
);

  import mmts_pkg::*;

  logic [TW-1:0] row_q;
  logic [VW-1:0] col_q;
  logic          col_last;
  logic          row_last;
  logic          accept;
  logic [AW-1:0] addr;

  assign col_last = ((VCW'(col_q) + VCW'(1)) == vms_i);
  assign row_last = ((TCW'(row_q) + TCW'(1)) == tasks_i);
  assign addr     = AW'(row_q) * AW'(MAX_VMS) + AW'(col_q);

  assign task_in.ready = q_ready_i;
  assign q_valid_o     = task_in.valid;
  assign q_item_o      = {col_last && row_last, addr, task_in.exec_time};
  assign accept        = task_in.valid && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (clear_i) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (col_last) begin
        col_q <= '0;
        if (row_last) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

endmodule

// File: src/mmts_back.sv
// ----------------------------------------------------------------------------
// Scheduling back end
// Writes the matrix, then runs max-min rounds over it and issues results.
// ----------------------------------------------------------------------------
module mmts_back #(
  parameter int MAX_TASKS = 16,
  parameter int MAX_VMS   = 8,
  parameter int TIME_BITS = 24,
  localparam int TW       = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int VW       = (MAX_VMS > 1) ? $clog2(MAX_VMS) : 1,
  localparam int AW       = (MAX_TASKS * MAX_VMS > 1) ? $clog2(MAX_TASKS * MAX_VMS) : 1,
  localparam int TCW      = $clog2(MAX_TASKS + 1),
  localparam int VCW      = $clog2(MAX_VMS + 1),
  localparam int ITEM_W   = 1 + AW + mmts_pkg::EXEC_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [VCW-1:0]    vms_i,
  input  logic [TCW-1:0]    tasks_i,
  input  logic              q_valid_i,
  input  logic [ITEM_W-1:0] q_item_i,
  output logic              q_ready_o,
  mmts_out_if.source        sched_out
);

  import mmts_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_PICK,
    ST_UPD
  } state_e;

  state_e                 state_q;
  logic [TW-1:0]          it_q;
  logic [VW-1:0]          iv_q;
  logic                   issue_q;
  logic                   pv_q;
  logic                   pfirst_q;
  logic                   plast_q;
  logic                   pskip_q;
  logic [TW-1:0]          pt_q;
  logic [VW-1:0]          pvv_q;
  logic [TIME_BITS-1:0]   cur_min_q;
  logic [VW-1:0]          cur_v_q;
  logic [TIME_BITS-1:0]   best_val_q;
  logic [TW-1:0]          best_t_q;
  logic [VW-1:0]          best_v_q;
  logic                   have_q;
  logic [MAX_TASKS-1:0]   done_q;
  logic [TCW-1:0]         round_q;
  logic [TOTAL_W-1:0]     total_q;

  logic                   out_valid_q;
  logic [TASK_IDX_W-1:0]  out_task_q;
  logic [VM_IDX_W-1:0]    out_vm_q;
  logic [CHOSEN_W-1:0]    out_chosen_q;
  logic [TOTAL_W-1:0]     out_total_q;
  logic                   out_last_q;

  logic [EXEC_W-1:0]      q_data;
  logic [AW-1:0]          q_addr;
  logic                   q_last;
  logic                   pop;
  logic                   iv_last;
  logic                   it_last;
  logic [VW-1:0]          rd_col;
  logic                   re;
  logic [AW-1:0]          raddr;
  logic [TIME_BITS-1:0]   rd_data;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [TIME_BITS-1:0]   wdata;
  logic [TIME_BITS:0]     wb_sum;
  logic [TIME_BITS-1:0]   wb_val;
  logic [TOTAL_W:0]       total_sum;
  logic [TOTAL_W-1:0]     total_next;
  logic [TIME_BITS-1:0]   row_min;
  logic [VW-1:0]          row_v;
  logic                   take_best;
  logic                   out_free;
  logic                   pick_fire;
  logic                   issue_done;

  assign q_data = q_item_i[EXEC_W-1:0];
  assign q_addr = q_item_i[EXEC_W +: AW];
  assign q_last = q_item_i[ITEM_W-1];

  assign q_ready_o  = (state_q == ST_LOAD);
  assign pop        = q_ready_o && q_valid_i;
  assign iv_last    = ((VCW'(iv_q) + VCW'(1)) == vms_i);
  assign it_last    = ((TCW'(it_q) + TCW'(1)) == tasks_i);
  assign issue_done = !issue_q && !pv_q;
  assign out_free   = !out_valid_q || sched_out.ready;
  assign pick_fire  = (state_q == ST_PICK) && out_free;

  assign rd_col = (state_q == ST_SCAN) ? iv_q : best_v_q;
  assign re     = issue_q;
  assign raddr  = AW'(it_q) * AW'(MAX_VMS) + AW'(rd_col);

  assign wb_sum = {1'b0, rd_data} + {1'b0, best_val_q};
  assign wb_val = wb_sum[TIME_BITS] ? '1 : wb_sum[TIME_BITS-1:0];

  assign we    = pop || ((state_q == ST_UPD) && pv_q && !pskip_q);
  assign waddr = pop ? q_addr : AW'(pt_q) * AW'(MAX_VMS) + AW'(best_v_q);
  assign wdata = pop ? TIME_BITS'(q_data) : wb_val;

  assign total_sum  = {1'b0, total_q} + (TOTAL_W + 1)'(best_val_q);
  assign total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];

  always_comb begin
    if (pfirst_q || (rd_data < cur_min_q)) begin
      row_min = rd_data;
      row_v   = pvv_q;
    end else begin
      row_min = cur_min_q;
      row_v   = cur_v_q;
    end
  end

  assign take_best = (state_q == ST_SCAN) && pv_q && plast_q && !pskip_q &&
                     (!have_q || (row_min > best_val_q));

  mmts_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_TASKS * MAX_VMS)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      it_q        <= '0;
      iv_q        <= '0;
      issue_q     <= 1'b0;
      pv_q        <= 1'b0;
      have_q      <= 1'b0;
      done_q      <= '0;
      round_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pv_q <= issue_q;
      if (out_valid_q && sched_out.ready && !pick_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (pop && q_last) begin
            state_q <= ST_SCAN;
            it_q    <= '0;
            iv_q    <= '0;
            issue_q <= 1'b1;
            have_q  <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (issue_q) begin
            if (iv_last) begin
              iv_q <= '0;
              if (it_last) begin
                issue_q <= 1'b0;
              end else begin
                it_q <= it_q + 1'b1;
              end
            end else begin
              iv_q <= iv_q + 1'b1;
            end
          end
          if (take_best) begin
            have_q <= 1'b1;
          end
          if (issue_done) begin
            state_q <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (out_free) begin
            out_valid_q      <= 1'b1;
            done_q[best_t_q] <= 1'b1;
            round_q          <= round_q + 1'b1;
            total_q          <= total_next;
            state_q          <= ST_UPD;
            it_q             <= '0;
            issue_q          <= 1'b1;
          end
        end
        ST_UPD: begin
          if (issue_q) begin
            if (it_last) begin
              issue_q <= 1'b0;
            end else begin
              it_q <= it_q + 1'b1;
            end
          end
          if (issue_done) begin
            if (round_q == tasks_i) begin
              done_q  <= '0;
              round_q <= '0;
              total_q <= '0;
              state_q <= ST_LOAD;
            end else begin
              state_q <= ST_SCAN;
              it_q    <= '0;
              iv_q    <= '0;
              issue_q <= 1'b1;
              have_q  <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pt_q     <= it_q;
    pvv_q    <= iv_q;
    pfirst_q <= (iv_q == '0);
    plast_q  <= iv_last;
    pskip_q  <= done_q[it_q];
    if ((state_q == ST_SCAN) && pv_q) begin
      cur_min_q <= row_min;
      cur_v_q   <= row_v;
    end
    if (take_best) begin
      best_val_q <= row_min;
      best_t_q   <= pt_q;
      best_v_q   <= row_v;
    end
    if (pick_fire) begin
      out_task_q   <= TASK_IDX_W'(best_t_q);
      out_vm_q     <= VM_IDX_W'(best_v_q);
      out_chosen_q <= CHOSEN_W'(best_val_q);
      out_total_q  <= total_next;
      out_last_q   <= ((round_q + 1'b1) == tasks_i);
    end
  end

  assign sched_out.valid         = out_valid_q;
  assign sched_out.task_index    = out_task_q;
  assign sched_out.vm_index      = out_vm_q;
  assign sched_out.chosen_time   = out_chosen_q;
  assign sched_out.running_total = out_total_q;
  assign sched_out.is_last       = out_last_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Max-min task scheduler testbench
// Loads completion-time matrices of varied shapes through the input channel
// and checks every assignment beat against a local max-min schedule model.
// Both channels idle at random; configuration writes come only between schedules, some mid-load.
// ----------------------------------------------------------------------------
module tb;
  import mmts_pkg::*;

  localparam int N_TASKS    = 16;
  localparam int N_VMS      = 8;
  localparam int SETTLE_CYC = 300;
  localparam int RAND_BEATS = 120;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    ACT_BEAT,
    ACT_SETTLE,
    ACT_CFG
  } act_e;

  typedef struct {
    act_e                  kind;
    logic [EXEC_W-1:0]     value;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } feed_t;

  typedef struct packed {
    logic [TASK_IDX_W-1:0] task_index;
    logic [VM_IDX_W-1:0]   vm_index;
    logic [CHOSEN_W-1:0]   chosen_time;
    logic [TOTAL_W-1:0]    running_total;
    logic                  is_last;
  } assign_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mmts_in_if  task_in_if ();
  mmts_out_if sched_out_if ();

  max_min_task_scheduler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .task_in    (task_in_if),
    .sched_out  (sched_out_if)
  );

  feed_t   feed_q[$];
  assign_t assign_q[$];

  // schedule model state
  logic [CHOSEN_W-1:0]   time_grid [N_TASKS][N_VMS];
  logic [VM_CNT_W-1:0]   vm_reg   = VM_COUNT_RST;
  logic [TASK_CNT_W-1:0] task_reg = TASK_COUNT_RST;
  int                    fill_cnt = 0;

  // stimulus plan mirrors
  int plan_vms      = N_VMS;
  int plan_tasks    = N_TASKS;
  int plan_task_raw = N_TASKS;
  int n_planned     = 0;

  int  n_loaded  = 0;
  int  n_scheds  = 0;
  int  n_checked = 0;
  int  n_cfg     = 0;
  int  n_err     = 0;
  int  in_gap    = 0;
  int  out_gap   = 0;
  int  quiet     = 0;
  bit  in_calm   = 1'b0;
  bit  out_calm  = 1'b0;

  function automatic int clamp_count(input int raw, input int hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [EXEC_W-1:0] rand_time(input int style);
    case (style)
      1:       return EXEC_W'($urandom_range(0, 3));
      2:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      3:       return EXEC_W'($urandom_range(60000, 65535));
      default: return EXEC_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_VM_COUNT: begin
        vm_reg   = data[VM_CNT_W-1:0];
        fill_cnt = 0;
      end
      CFG_TASK_COUNT: begin
        task_reg = data[TASK_CNT_W-1:0];
        fill_cnt = 0;
      end
      default: ;
    endcase
  endtask

  // store one matrix value; on the last one, run every round of the schedule
  task automatic load_and_schedule(input logic [EXEC_W-1:0] t);
    int                   vms;
    int                   tasks;
    int                   pick_t;
    int                   pick_v;
    int                   min_v;
    logic [CHOSEN_W-1:0]  pick_val;
    logic [CHOSEN_W-1:0]  min_val;
    logic [CHOSEN_W:0]    sum;
    logic [TOTAL_W:0]     tot;
    logic [TOTAL_W-1:0]   run_total;
    logic [N_TASKS-1:0]   taken;
    bit                   found;
    assign_t              a;
    vms   = clamp_count(int'(vm_reg), N_VMS);
    tasks = clamp_count(int'(task_reg), N_TASKS);
    time_grid[fill_cnt / vms][fill_cnt % vms] = CHOSEN_W'(t);
    fill_cnt++;
    if (fill_cnt < vms * tasks) return;
    fill_cnt  = 0;
    taken     = '0;
    run_total = '0;
    n_scheds++;
    for (int k = 0; k < tasks; k++) begin
      found    = 1'b0;
      pick_t   = 0;
      pick_v   = 0;
      pick_val = '0;
      for (int ti = 0; ti < tasks; ti++) begin
        if (!taken[ti]) begin
          min_val = time_grid[ti][0];
          min_v   = 0;
          for (int vi = 1; vi < vms; vi++) begin
            if (time_grid[ti][vi] < min_val) begin
              min_val = time_grid[ti][vi];
              min_v   = vi;
            end
          end
          if (!found || min_val > pick_val) begin
            found    = 1'b1;
            pick_val = min_val;
            pick_t   = ti;
            pick_v   = min_v;
          end
        end
      end
      taken[pick_t] = 1'b1;
      for (int ti = 0; ti < tasks; ti++) begin
        if (!taken[ti]) begin
          sum = time_grid[ti][pick_v] + pick_val;
          time_grid[ti][pick_v] = sum[CHOSEN_W] ? '1 : sum[CHOSEN_W-1:0];
        end
      end
      tot       = run_total + pick_val;
      run_total = tot[TOTAL_W] ? '1 : tot[TOTAL_W-1:0];
      a.task_index    = TASK_IDX_W'(pick_t);
      a.vm_index      = VM_IDX_W'(pick_v);
      a.chosen_time   = pick_val;
      a.running_total = run_total;
      a.is_last       = (k == tasks - 1);
      assign_q.push_back(a);
    end
  endtask

  task automatic push_beat(input logic [EXEC_W-1:0] v);
    feed_t f;
    f = '{kind: ACT_BEAT, value: v, idx: CFG_VM_COUNT, data: '0};
    feed_q.push_back(f);
    n_planned++;
  endtask

  task automatic push_settle();
    feed_t f;
    f = '{kind: ACT_SETTLE, value: '0, idx: CFG_VM_COUNT, data: '0};
    feed_q.push_back(f);
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    feed_t f;
    push_settle();
    f = '{kind: ACT_CFG, value: '0, idx: idx, data: data};
    feed_q.push_back(f);
    case (idx)
      CFG_VM_COUNT: plan_vms = clamp_count(int'(data[VM_CNT_W-1:0]), N_VMS);
      CFG_TASK_COUNT: begin
        plan_task_raw = int'(data);
        plan_tasks    = clamp_count(plan_task_raw, N_TASKS);
      end
      default: ;
    endcase
  endtask

  task automatic push_matrix(input int style);
    for (int i = 0; i < plan_vms * plan_tasks; i++) push_beat(rand_time(style));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: completion-time beats and register writes
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic                  nxt_valid;
    logic [EXEC_W-1:0]     nxt_time;
    logic                  nxt_we;
    logic [CFG_IDX_W-1:0]  nxt_idx;
    logic [CFG_DATA_W-1:0] nxt_data;
    if (!rst_ni) begin
      task_in_if.valid     <= 1'b0;
      task_in_if.exec_time <= '0;
      cfg_we               <= 1'b0;
      cfg_idx              <= CFG_VM_COUNT;
      cfg_data             <= '0;
      in_gap = 0;
      quiet  = 0;
    end else begin
      nxt_valid = task_in_if.valid && !task_in_if.ready;
      nxt_time  = task_in_if.exec_time;
      nxt_we    = 1'b0;
      nxt_idx   = cfg_idx;
      nxt_data  = cfg_data;
      if (task_in_if.valid && task_in_if.ready) begin
        load_and_schedule(task_in_if.exec_time);
        n_loaded++;
      end
      if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (feed_q.size() > 0) begin
          case (feed_q[0].kind)
            ACT_BEAT: begin
              nxt_valid = 1'b1;
              nxt_time  = feed_q[0].value;
              void'(feed_q.pop_front());
              in_gap = pick_gap(in_calm);
            end
            ACT_SETTLE: begin
              // hold until every assignment is in and the last update is over
              if (assign_q.size() != 0) begin
                quiet = 0;
              end else if (quiet < SETTLE_CYC) begin
                quiet++;
              end else begin
                quiet = 0;
                void'(feed_q.pop_front());
              end
            end
            default: begin
              nxt_we   = 1'b1;
              nxt_idx  = feed_q[0].idx;
              nxt_data = feed_q[0].data;
              apply_cfg(nxt_idx, nxt_data);
              n_cfg++;
              void'(feed_q.pop_front());
            end
          endcase
        end
      end
      task_in_if.valid     <= nxt_valid;
      task_in_if.exec_time <= nxt_time;
      cfg_we               <= nxt_we;
      cfg_idx              <= nxt_idx;
      cfg_data             <= nxt_data;
    end
  end

  // monitor: assignment beats against the model
  always @(posedge clk_i or negedge rst_ni) begin : watch
    assign_t got;
    assign_t want;
    if (!rst_ni) begin
      sched_out_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (sched_out_if.valid && sched_out_if.ready) begin
        got = '{sched_out_if.task_index, sched_out_if.vm_index, sched_out_if.chosen_time,
                sched_out_if.running_total, sched_out_if.is_last};
        if (assign_q.size() == 0) begin
          n_err++;
          $display("%0t tb: unexpected beat task %0d vm %0d time %0d total %0d last %0b",
                   $realtime, got.task_index, got.vm_index, got.chosen_time,
                   got.running_total, got.is_last);
        end else begin
          want = assign_q.pop_front();
          n_checked++;
          if (got !== want) begin
            n_err++;
            $display("%0t tb: mismatch expected task %0d vm %0d time %0d total %0d last %0b",
                     $realtime, want.task_index, want.vm_index, want.chosen_time,
                     want.running_total, want.is_last);
            $display("%0t tb:          actual   task %0d vm %0d time %0d total %0d last %0b",
                     $realtime, got.task_index, got.vm_index, got.chosen_time,
                     got.running_total, got.is_last);
          end
        end
      end
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
      if (out_gap > 0) begin
        out_gap--;
        sched_out_if.ready <= 1'b0;
      end else begin
        sched_out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap(out_calm);
      end
    end
  end

  initial begin : stimulus
    int style;
    int cut;
    int vm_pick;
    int task_pick;

    // zero counts act as one: a single-entry schedule at full scale
    push_cfg(CFG_VM_COUNT, '0);
    push_cfg(CFG_TASK_COUNT, '0);
    push_beat('1);
    // unknown index leaves the shape alone
    push_cfg(CFG_SPARE, '1);
    // abandon a partial load, then ties on both VM and task
    push_cfg(CFG_TASK_COUNT, 5'd2);
    push_beat(EXEC_W'(7));
    push_cfg(CFG_VM_COUNT, 5'd2);
    repeat (4) push_beat(EXEC_W'(4));
    // counts above the maximum clamp
    push_cfg(CFG_VM_COUNT, '1);
    push_cfg(CFG_TASK_COUNT, 5'd1);
    push_matrix(2);
    // one VM, all tasks at the top: accumulated times saturate
    push_cfg(CFG_VM_COUNT, 5'd1);
    push_cfg(CFG_TASK_COUNT, '1);
    repeat (16) push_beat('1);

    while (n_planned < RAND_BEATS) begin
      if ($urandom_range(0, 2) != 0) begin
        vm_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * $urandom_range(9, 31)
                                              : $urandom_range(1, 4);
        task_pick = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        push_cfg(CFG_VM_COUNT, CFG_DATA_W'(vm_pick));
        push_cfg(CFG_TASK_COUNT, CFG_DATA_W'(task_pick));
      end
      if ($urandom_range(0, 7) == 0 && plan_vms * plan_tasks > 1) begin
        cut = $urandom_range(1, plan_vms * plan_tasks - 1);
        repeat (cut) push_beat(rand_time(0));
        push_cfg(CFG_TASK_COUNT, CFG_DATA_W'(plan_task_raw));
      end
      if ($urandom_range(0, 5) == 0) push_settle();
      style = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 3);
      push_matrix(style);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() != 0 || task_in_if.valid) @(posedge clk_i);
    while (assign_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    $display("tb: %0d completion times loaded into %0d schedules, %0d register writes",
             n_loaded, n_scheds, n_cfg);
    $display("tb: %0d assignment beats checked, %0d errors", n_checked, n_err);
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("tb: timeout");
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/mmts_pkg.sv
src/mmts_in_if.sv
src/mmts_out_if.sv
src/mmts_ram.sv
src/mmts_fifo.sv
src/mmts_front.sv
src/mmts_back.sv
src/max_min_task_scheduler.sv
test/tb.sv
